[rtl/ema_ftd_pkg.sv]
// Shared types and constants for the EMA filter with timed threshold detection.
`default_nettype none
package ema_ftd_pkg;

  localparam int ACC_WIDTH   = 32;
  localparam int TIME_WIDTH  = 32;
  localparam int SMP_WIDTH   = 16;
  localparam int SHIFT_WIDTH = 4;
  localparam int HOLD_WIDTH  = 16;
  localparam int HOLD_MARGIN = 2;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_EMA_SHIFT    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INVERSE_MODE = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_HOLD_TIME_MS = 2'd3;

  typedef struct packed {
    logic                        req_type;
    logic signed [SMP_WIDTH-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_WIDTH-1:0] filtered;
    logic                        detected;
    logic                        changed;
  } out_item_t;

  typedef struct packed {
    logic [SHIFT_WIDTH-1:0]      ema_shift;
    logic signed [SMP_WIDTH-1:0] threshold;
    logic                        inverse_mode;
    logic [HOLD_WIDTH-1:0]       hold_time_ms;
  } cfg_t;

  typedef struct packed {
    logic sample_en;
    logic tick_en;
  } step_t;

endpackage
`default_nettype wire

[rtl/ema_ftd_filter.sv]
// Shift-based exponential moving average accumulator and filtered output.
`default_nettype none
module ema_ftd_filter (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     sample_en,
  input  wire logic signed [ema_ftd_pkg::SMP_WIDTH-1:0] sample,
  input  wire logic [ema_ftd_pkg::SHIFT_WIDTH-1:0]      ema_shift,
  output logic signed [ema_ftd_pkg::SMP_WIDTH-1:0]      filtered
);

  logic signed [ema_ftd_pkg::ACC_WIDTH-1:0] acc_r;
  logic signed [ema_ftd_pkg::ACC_WIDTH-1:0] acc_nxt;
  logic signed [ema_ftd_pkg::ACC_WIDTH-1:0] acc_shr;
  logic signed [ema_ftd_pkg::ACC_WIDTH-1:0] new_shr;
  logic signed [ema_ftd_pkg::ACC_WIDTH-1:0] smp_ext;

  always_comb begin
    smp_ext  = {{(ema_ftd_pkg::ACC_WIDTH - ema_ftd_pkg::SMP_WIDTH)
                 {sample[ema_ftd_pkg::SMP_WIDTH-1]}},
                sample};
    acc_shr  = acc_r >>> ema_shift;
    acc_nxt  = acc_r - acc_shr + smp_ext;
    new_shr  = acc_nxt >>> ema_shift;
    filtered = new_shr[ema_ftd_pkg::SMP_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (sample_en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/ema_ftd_detect.sv]
// Millisecond timebase and timed threshold detector.
`default_nettype none
module ema_ftd_detect (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire ema_ftd_pkg::step_t                       step,
  input  wire logic signed [ema_ftd_pkg::SMP_WIDTH-1:0] filtered,
  input  wire ema_ftd_pkg::cfg_t                        cfg,
  output logic                                          detected,
  output logic                                          changed
);

  logic [ema_ftd_pkg::TIME_WIDTH-1:0] now_r;
  logic [ema_ftd_pkg::TIME_WIDTH-1:0] last_r;
  logic                               flag_r;
  logic [ema_ftd_pkg::TIME_WIDTH-1:0] elapsed;
  logic [ema_ftd_pkg::TIME_WIDTH-1:0] limit;
  logic                               in_range;

  always_comb begin
    in_range = cfg.inverse_mode ? (filtered >= cfg.threshold) : (filtered <= cfg.threshold);
    elapsed  = in_range ? '0 : (now_r - last_r);
    limit    = ema_ftd_pkg::TIME_WIDTH'(cfg.hold_time_ms)
             + ema_ftd_pkg::TIME_WIDTH'(ema_ftd_pkg::HOLD_MARGIN);
    detected = (elapsed >= limit);
    changed  = detected ^ flag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      last_r <= '0;
      flag_r <= 1'b0;
    end else begin
      if (step.tick_en) begin
        now_r <= now_r + ema_ftd_pkg::TIME_WIDTH'(1);
      end
      if (step.sample_en) begin
        flag_r <= detected;
        if (in_range) begin
          last_r <= now_r;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ema_filter_timed_threshold_detect.sv]
// Top level: EMA low-pass filter with timed threshold detection.
// Each input beat is a signed sample or a one-millisecond tick. The block takes one beat
// every cycle unless stalled; a sample is captured in the input register, and the
// accumulator and detector update as it moves into the output register. The input
// stalls only while both registers are full and the result is stalled. Ticks advance
// the time counter and give no result. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata, by the user only while idle; the block does not enforce it.
`default_nettype none
module ema_filter_timed_threshold_detect (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          in_valid,
  output logic                                               in_stall,
  input  wire ema_ftd_pkg::in_item_t                         in_data,
  output logic                                               out_valid,
  input  wire logic                                          out_stall,
  output ema_ftd_pkg::out_item_t                             out_data,
  input  wire logic                                          cfg_we,
  input  wire logic [ema_ftd_pkg::CFG_IDX_WIDTH-1:0]         cfg_index,
  input  wire logic [ema_ftd_pkg::CFG_DATA_WIDTH-1:0]        cfg_wdata
);

  ema_ftd_pkg::cfg_t     cfg_r;
  ema_ftd_pkg::in_item_t s0_r;
  logic                  s0_valid_r;
  ema_ftd_pkg::out_item_t out_r;
  logic                  out_valid_r;
  logic                  s0_adv;
  logic                  in_acc;
  ema_ftd_pkg::step_t    step;
  logic signed [ema_ftd_pkg::SMP_WIDTH-1:0] filtered;
  logic                  detected;
  logic                  changed;

  always_comb begin
    s0_adv         = s0_valid_r && (!out_valid_r || !out_stall);
    in_stall       = s0_valid_r && !s0_adv;
    in_acc         = in_valid && !in_stall;
    step.sample_en = s0_adv && (s0_r.req_type == ema_ftd_pkg::REQ_SAMPLE);
    step.tick_en   = s0_adv && (s0_r.req_type == ema_ftd_pkg::REQ_TICK);
    out_valid      = out_valid_r;
    out_data       = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_shift    <= ema_ftd_pkg::SHIFT_WIDTH'(4);
      cfg_r.threshold    <= '0;
      cfg_r.inverse_mode <= 1'b0;
      cfg_r.hold_time_ms <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ema_ftd_pkg::CFG_EMA_SHIFT:
          cfg_r.ema_shift    <= cfg_wdata[ema_ftd_pkg::SHIFT_WIDTH-1:0];
        ema_ftd_pkg::CFG_THRESHOLD:
          cfg_r.threshold    <= cfg_wdata[ema_ftd_pkg::SMP_WIDTH-1:0];
        ema_ftd_pkg::CFG_INVERSE_MODE:
          cfg_r.inverse_mode <= cfg_wdata[0];
        ema_ftd_pkg::CFG_HOLD_TIME_MS:
          cfg_r.hold_time_ms <= cfg_wdata[ema_ftd_pkg::HOLD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s0_valid_r <= 1'b1;
      end else if (s0_adv) begin
        s0_valid_r <= 1'b0;
      end
      if (s0_adv) begin
        out_valid_r <= step.sample_en;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_r <= in_data;
    end
    if (step.sample_en) begin
      out_r.filtered <= filtered;
      out_r.detected <= detected;
      out_r.changed  <= changed;
    end
  end

  ema_ftd_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_en    (step.sample_en),
    .sample       (s0_r.sample),
    .ema_shift    (cfg_r.ema_shift),
    .filtered     (filtered)
  );

  ema_ftd_detect u_detect (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .filtered (filtered),
    .cfg      (cfg_r),
    .detected (detected),
    .changed  (changed)
  );

endmodule
`default_nettype wire
